### hdl/mpnf_pkg.sv
package mpnf_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int PALETTE_ENTRIES = 256;
    localparam int COL_W           = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH      = 3 * MAX_WIDTH;
    localparam int LINE_AW         = COL_W + 2;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int SUM_W           = 11;
    localparam int RECIP_W         = 17;
    localparam int RECIP_SH        = 16;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MASK   = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
        logic [3:0]       cnt;
    } t_acc;

    typedef struct packed {
        logic dxn;
        logic dxp;
        logic dyn;
        logic dyp;
    } t_nb;

    function automatic t_nb nb_offs(input logic [2:0] k);
        t_nb o;
        o = '0;
        unique case (k)
            3'd0: begin o.dxn = 1'b1; o.dyn = 1'b1; end
            3'd1: begin o.dxn = 1'b1; end
            3'd2: begin o.dxn = 1'b1; o.dyp = 1'b1; end
            3'd3: begin o.dyn = 1'b1; end
            3'd4: begin o.dyp = 1'b1; end
            3'd5: begin o.dxp = 1'b1; o.dyn = 1'b1; end
            3'd6: begin o.dxp = 1'b1; end
            default: begin o.dxp = 1'b1; o.dyp = 1'b1; end
        endcase
        return o;
    endfunction

    // ceil(2^16 / d); exact floor division for sums below 2048, d up to 8
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
        logic [RECIP_W-1:0] v;
        unique case (d)
            4'd1:    v = 17'd65536;
            4'd2:    v = 17'd32768;
            4'd3:    v = 17'd21846;
            4'd4:    v = 17'd16384;
            4'd5:    v = 17'd13108;
            4'd6:    v = 17'd10923;
            4'd7:    v = 17'd9363;
            4'd8:    v = 17'd8192;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] dec3(input logic [1:0] x);
        return (x == 2'd0) ? 2'd2 : 2'(x - 2'd1);
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : 2'(x + 2'd1);
    endfunction

endpackage

### hdl/masked_pixel_neighbor_color_fill_top.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_stall | operation, pixel_index, palette_address,
//         |           |                         | palette_color
// out     | output    | o_out_valid / i_out_stall | red, green, blue, alpha, end_of_run,
//         |           |                         | end_of_frame
// cfg     | input     | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// Palette loads and ignored items do not start the sequencer. Each result is
// built by a sequencer around the registered line-store and palette read ports:
// a plain pixel goes through read, palette read, capture and output; a masked
// one through its own read, a check of each of 8 neighbors, read and sum of the
// usable ones, averaging and output. The input stalls while the sequencer is busy.
// Reset is synchronous, active low; stores need no clearing pass.
// The output register frees the sequencer: the next item is taken while a
// result waits; a stalled result holds the sequencer only for its next result.
module masked_pixel_neighbor_color_fill_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_pixel_index,
    input  logic [7:0]  i_palette_address,
    input  logic [31:0] i_palette_color,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_end_of_run,
    output logic        o_end_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int CW = mpnf_pkg::COL_W;
    localparam int LA = mpnf_pkg::LINE_AW;
    localparam int PA = mpnf_pkg::PAL_AW;
    localparam logic [10:0] MAXW = 11'(mpnf_pkg::MAX_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_P, S_PAL, S_NCHK, S_NQ, S_NACC, S_DIV, S_DIVW, S_OUT
    } t_state;

    // memories
    logic [31:0] r_pal [0:mpnf_pkg::PALETTE_ENTRIES-1];
    logic [7:0]  r_line [0:mpnf_pkg::LINE_DEPTH-1];
    logic [31:0] r_pq;
    logic [7:0]  r_lq;

    // config
    logic [10:0] r_width, r_height;
    logic [8:0]  r_mask;

    // frame position
    logic [CW-1:0] r_col;
    logic [10:0]   r_row;
    logic [10:0]   r_drain;
    logic [1:0]    r_rm3;

    // current emit job
    t_state        r_state;
    logic [CW-1:0] r_x, r_x2;
    logic [1:0]    r_ym;
    logic          r_ytop, r_below, r_eor, r_eof, r_has2;
    logic [2:0]    r_k;
    mpnf_pkg::t_acc r_acc;
    logic [7:0]    r_rr, r_rg, r_rb, r_ra;

    // output register
    logic        r_ovalid;
    logic [7:0]  r_ored, r_ogreen, r_oblue, r_oalpha;
    logic        r_oeor, r_oeof;

    logic [7:0]  avg_r, avg_g, avg_b;

    // combinational
    logic [10:0]   w, h;
    logic [CW-1:0] wm1, c, dc;
    logic          last, dlast, acc_in, slot_free;
    logic          l_rd_en, p_rd_en, l_wr_en, p_wr_en;
    logic [LA-1:0] l_rd_addr;
    logic [PA-1:0] p_rd_addr;
    mpnf_pkg::t_nb nb;
    logic          nb_ok, q_masked;
    logic [CW-1:0] nx;
    logic [1:0]    nrow;

    function automatic logic is_mask(input logic [7:0] p, input logic [8:0] m);
        return !m[8] && (m[7:0] == p);
    endfunction

    assign w = (r_width == 11'd0) ? 11'd1 : ((r_width > MAXW) ? MAXW : r_width);
    assign h = (r_height == 11'd0) ? 11'd1 : r_height;
    assign wm1 = CW'(w - 11'd1);
    assign c = ({1'b0, r_col} < w) ? r_col : wm1;
    assign last = (c == wm1);
    assign dc = (r_drain < w) ? CW'(r_drain) : wm1;
    assign dlast = (dc == wm1);

    assign o_in_stall = (r_state != S_IDLE);
    assign acc_in = i_in_valid && !o_in_stall;
    assign slot_free = !r_ovalid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign l_wr_en = acc_in && (i_operation == mpnf_pkg::OP_PIXEL) && (r_row < h);
    assign p_wr_en = acc_in && (i_operation == mpnf_pkg::OP_LOAD);

    // neighbor bounds
    assign nb = mpnf_pkg::nb_offs(r_k);
    assign nb_ok = !(nb.dxn && (r_x == '0))
                && !(nb.dxp && ((12'(r_x) + 12'd1) >= 12'(w)))
                && !(nb.dyn && r_ytop)
                && !(nb.dyp && !r_below);
    assign nx = nb.dxp ? CW'(r_x + 1'b1) : (nb.dxn ? CW'(r_x - 1'b1) : r_x);
    assign nrow = nb.dyn ? mpnf_pkg::dec3(r_ym)
                : (nb.dyp ? mpnf_pkg::inc3(r_ym) : r_ym);
    assign q_masked = is_mask(r_lq, r_mask);

    always_comb begin
        l_rd_en   = 1'b0;
        l_rd_addr = {r_ym, r_x};
        p_rd_en   = 1'b0;
        p_rd_addr = PA'(r_lq);
        case (r_state)
            S_RD:   l_rd_en = 1'b1;
            S_NCHK: begin
                l_rd_en   = nb_ok;
                l_rd_addr = {nrow, nx};
            end
            S_P, S_NQ: p_rd_en = !q_masked;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (l_wr_en) begin
            r_line[{r_rm3, c}] <= i_pixel_index;
        end
        if (l_rd_en) begin
            r_lq <= r_line[l_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_wr_en) begin
            r_pal[PA'(i_palette_address)] <= i_palette_color;
        end
        if (p_rd_en) begin
            r_pq <= r_pal[p_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MAXW;
            r_height <= 11'd1024;
            r_mask   <= 9'h1FF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mpnf_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                mpnf_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                mpnf_pkg::CFG_MASK:   r_mask   <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    mpnf_avg u_avg (
        .i_clk   (i_clk),
        .i_acc   (r_acc),
        .o_red   (avg_r),
        .o_green (avg_g),
        .o_blue  (avg_b)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_drain  <= '0;
            r_rm3    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // S_OUT reloads the slot itself
            if (r_ovalid && !i_out_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in && (i_operation == mpnf_pkg::OP_PIXEL) && (r_row < h)) begin
                        r_ym    <= mpnf_pkg::dec3(r_rm3);
                        r_ytop  <= (r_row == 11'd1);
                        r_below <= 1'b1;
                        r_eof   <= 1'b0;
                        r_x2    <= wm1;
                        if (r_row != 11'd0 && c != '0) begin
                            r_x     <= CW'(c - 1'b1);
                            r_eor   <= !last;
                            r_has2  <= last;
                            r_state <= S_RD;
                        end else if (r_row != 11'd0 && last) begin
                            r_x     <= wm1;
                            r_eor   <= 1'b1;
                            r_has2  <= 1'b0;
                            r_state <= S_RD;
                        end
                        if (last) begin
                            r_col <= '0;
                            r_row <= r_row + 11'd1;
                            r_rm3 <= mpnf_pkg::inc3(r_rm3);
                        end else begin
                            r_col <= CW'(c + 1'b1);
                        end
                    end else if (acc_in && (i_operation == mpnf_pkg::OP_DRAIN)
                                 && (r_row >= h) && (r_row != 11'd0)) begin
                        r_x     <= dc;
                        r_ym    <= mpnf_pkg::dec3(r_rm3);
                        r_ytop  <= (r_row == 11'd1);
                        r_below <= 1'b0;
                        r_eor   <= 1'b1;
                        r_eof   <= dlast;
                        r_has2  <= 1'b0;
                        r_state <= S_RD;
                        if (dlast) begin
                            r_drain <= '0;
                            r_col   <= '0;
                            r_row   <= '0;
                            r_rm3   <= '0;
                        end else begin
                            r_drain <= 11'(dc) + 11'd1;
                        end
                    end
                end
                S_RD: r_state <= S_P;
                S_P: begin
                    if (q_masked) begin
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= S_NCHK;
                    end else begin
                        r_state <= S_PAL;
                    end
                end
                S_PAL: begin
                    r_rr    <= r_pq[7:0];
                    r_rg    <= r_pq[15:8];
                    r_rb    <= r_pq[23:16];
                    r_ra    <= r_pq[31:24];
                    r_state <= S_OUT;
                end
                S_NCHK: begin
                    if (nb_ok) begin
                        r_state <= S_NQ;
                    end else if (r_k == 3'd7) begin
                        r_state <= S_DIV;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_NQ: begin
                    if (!q_masked) begin
                        r_state <= S_NACC;
                    end else if (r_k == 3'd7) begin
                        r_state <= S_DIV;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_NCHK;
                    end
                end
                S_NACC: begin
                    r_acc.r   <= r_acc.r + 11'(r_pq[7:0]);
                    r_acc.g   <= r_acc.g + 11'(r_pq[15:8]);
                    r_acc.b   <= r_acc.b + 11'(r_pq[23:16]);
                    r_acc.cnt <= r_acc.cnt + 4'd1;
                    if (r_k == 3'd7) begin
                        r_state <= S_DIV;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_NCHK;
                    end
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: begin
                    r_rr    <= avg_r;
                    r_rg    <= avg_g;
                    r_rb    <= avg_b;
                    r_ra    <= 8'd0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_ored   <= r_rr;
                        r_ogreen <= r_rg;
                        r_oblue  <= r_rb;
                        r_oalpha <= r_ra;
                        r_oeor   <= r_eor;
                        r_oeof   <= r_eof;
                        if (r_has2) begin
                            r_x     <= r_x2;
                            r_eor   <= 1'b1;
                            r_has2  <= 1'b0;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_red          = r_ored;
    assign o_green        = r_ogreen;
    assign o_blue         = r_oblue;
    assign o_alpha        = r_oalpha;
    assign o_end_of_run   = r_oeor;
    assign o_end_of_frame = r_oeof;

endmodule

### hdl/mpnf_avg.sv
module mpnf_avg (
    input  logic            i_clk,
    input  mpnf_pkg::t_acc  i_acc,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);

    localparam int PW = mpnf_pkg::SUM_W + mpnf_pkg::RECIP_W;

    logic [mpnf_pkg::RECIP_W-1:0] rc;
    logic [PW-1:0] pr, pg, pb;

    assign rc = mpnf_pkg::recip(i_acc.cnt);
    assign pr = PW'(i_acc.r) * PW'(rc);
    assign pg = PW'(i_acc.g) * PW'(rc);
    assign pb = PW'(i_acc.b) * PW'(rc);

    always_ff @(posedge i_clk) begin
        o_red   <= pr[mpnf_pkg::RECIP_SH +: 8];
        o_green <= pg[mpnf_pkg::RECIP_SH +: 8];
        o_blue  <= pb[mpnf_pkg::RECIP_SH +: 8];
    end

endmodule

### hdl/mpnf_checker.sv
module mpnf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_operation,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [7:0]  o_alpha,
    input logic        o_end_of_run,
    input logic        o_end_of_frame
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_alpha) && $stable(o_end_of_run)
            && $stable(o_end_of_frame))
        else $error("stalled result changed");

    a_eof_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_end_of_run)
        else $error("end of frame without end of run");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == mpnf_pkg::OP_LOAD) |=> !o_in_stall)
        else $error("palette load held input");

endmodule

bind masked_pixel_neighbor_color_fill_top mpnf_checker u_mpnf_checker (.*);

### verif/tb_masked_pixel_neighbor_color_fill_top.sv
module tb_masked_pixel_neighbor_color_fill_top;

    // Cycles with no transfer on any channel before the run is abandoned.
    // Worst legit quiet stretch: long receiver hold (HOLD_CYC) plus a masked result.
    localparam int IDLE_LIMIT  = 5000;
    // Longest single result (masked pixel, 8 neighbors) with margin.
    localparam int SETTLE_CYC  = 60;
    localparam int HOLD_CYC    = 400;
    localparam int RAND_ITEMS  = 160;
    localparam int QUIET_ITEMS = 60;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       eor;
        logic       eof;
    } t_rgba;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation       = '0;
    logic [7:0]  i_pixel_index     = '0;
    logic [7:0]  i_palette_address = '0;
    logic [31:0] i_palette_color   = '0;
    logic        o_out_valid;
    logic        i_out_stall       = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        o_end_of_run;
    logic        o_end_of_frame;
    logic        i_cfg_valid       = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index       = '0;
    logic [10:0] i_cfg_data        = '0;

    masked_pixel_neighbor_color_fill_top u_dut (.*);

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Color-fill predictor: private copy of palette, line rows, counters
    // and registers. Registers mirror what was written on the cfg port.
    // ------------------------------------------------------------------
    logic [31:0] pal_mem [0:mpnf_pkg::PALETTE_ENTRIES-1];
    logic [7:0]  row_mem [0:3*mpnf_pkg::MAX_WIDTH-1];
    int unsigned col_pos, row_pos, drain_pos;
    logic [10:0] reg_width  = 11'd1024;
    logic [10:0] reg_height = 11'd1024;
    logic [8:0]  reg_mask   = 9'h1FF;

    t_rgba pixels_due[$];

    int unsigned errors      = 0;
    int unsigned sent_items  = 0;
    bit          quiet       = 1'b0;  // end of run: no idling on either side
    bit          tx_gaps     = 1'b1;
    bit          rx_bursts   = 1'b1;
    int unsigned holds_asked = 0;

    function automatic int unsigned width_now();
        if (reg_width == 11'd0) return 1;
        if (32'(reg_width) > mpnf_pkg::MAX_WIDTH) return mpnf_pkg::MAX_WIDTH;
        return 32'(reg_width);
    endfunction

    function automatic int unsigned height_now();
        return (reg_height == 11'd0) ? 1 : 32'(reg_height);
    endfunction

    function automatic bit is_masked(input logic [7:0] p);
        return !reg_mask[8] && (p == reg_mask[7:0]);
    endfunction

    function automatic logic [7:0] row_px(input int unsigned x, input int unsigned y);
        return row_mem[(y % 3) * mpnf_pkg::MAX_WIDTH + x];
    endfunction

    // Color of pixel (x, y); a masked pixel averages its unmasked neighbors.
    function automatic void queue_pixel(input int unsigned x, input int unsigned y,
                                        input bit below, input int unsigned w,
                                        input bit eor, input bit eof);
        logic [7:0]  p;
        logic [7:0]  q;
        logic [31:0] c;
        int unsigned cnt, sr, sg, sb;
        t_rgba       e;
        p = row_px(x, y);
        e.alpha = '0;
        if (is_masked(p)) begin
            cnt = 0; sr = 0; sg = 0; sb = 0;
            for (int dx = -1; dx <= 1; dx++) begin
                for (int dy = -1; dy <= 1; dy++) begin
                    if (dx == 0 && dy == 0) continue;
                    if (dx < 0 && x == 0) continue;
                    if (dx > 0 && x + 1 >= w) continue;
                    if (dy < 0 && y == 0) continue;
                    if (dy > 0 && !below) continue;
                    q = row_px(x + dx, y + dy);
                    if (is_masked(q)) continue;
                    c = pal_mem[q];
                    cnt++;
                    sr += 32'(c[7:0]);
                    sg += 32'(c[15:8]);
                    sb += 32'(c[23:16]);
                end
            end
            if (cnt != 0) begin
                sr /= cnt; sg /= cnt; sb /= cnt;
            end
            e.red = sr[7:0]; e.green = sg[7:0]; e.blue = sb[7:0];
        end else begin
            c = pal_mem[p];
            e.red = c[7:0]; e.green = c[15:8]; e.blue = c[23:16]; e.alpha = c[31:24];
        end
        e.eor = eor;
        e.eof = eof;
        pixels_due.push_back(e);
    endfunction

    function automatic void predict_item(input logic [1:0] op, input logic [7:0] px,
                                         input logic [7:0] addr, input logic [31:0] color);
        int unsigned w, h, c, r;
        bit          last;
        w = width_now();
        h = height_now();
        case (op)
            mpnf_pkg::OP_LOAD: pal_mem[addr] = color;
            mpnf_pkg::OP_PIXEL: begin
                if (row_pos >= h) return;  // drain pending: pixel dropped
                c = (col_pos < w) ? col_pos : w - 1;
                r = row_pos;
                row_mem[(r % 3) * mpnf_pkg::MAX_WIDTH + c] = px;
                last = (c == w - 1);
                if (r >= 1) begin
                    if (c >= 1) queue_pixel(c - 1, r - 1, 1'b1, w, !last, 1'b0);
                    if (last) queue_pixel(w - 1, r - 1, 1'b1, w, 1'b1, 1'b0);
                end
                if (last) begin
                    col_pos = 0;
                    row_pos = (row_pos + 1) & 32'h7FF;
                end else begin
                    col_pos = c + 1;
                end
            end
            mpnf_pkg::OP_DRAIN: begin
                if (row_pos < h || row_pos == 0) return;
                c = (drain_pos < w) ? drain_pos : w - 1;
                last = (c == w - 1);
                queue_pixel(c, row_pos - 1, 1'b0, w, 1'b1, last);
                if (last) begin
                    drain_pos = 0; col_pos = 0; row_pos = 0;
                end else begin
                    drain_pos = c + 1;
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Transfers in
    // ------------------------------------------------------------------
    // Valid stays high after a transfer unless a gap follows; callers that
    // wait for anything else go through pause_sender first.
    task automatic send_item(input logic [1:0] op, input logic [7:0] px,
                             input logic [7:0] addr, input logic [31:0] color);
        i_in_valid        <= 1'b1;
        i_operation       <= op;
        i_pixel_index     <= px;
        i_palette_address <= addr;
        i_palette_color   <= color;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(op, px, addr, color);
        sent_items++;
        if (!quiet && tx_gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic send_pixel(input logic [7:0] px);
        send_item(mpnf_pkg::OP_PIXEL, px, 8'($urandom_range(0, 255)), $urandom);
    endtask

    task automatic send_drain();
        send_item(mpnf_pkg::OP_DRAIN, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), $urandom);
    endtask

    task automatic pause_sender();
        i_in_valid <= 1'b0;
    endtask

    // Block idle: nothing owed, then let any result-free item finish.
    task automatic wait_idle();
        pause_sender();
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            mpnf_pkg::CFG_WIDTH:  reg_width  = data;
            mpnf_pkg::CFG_HEIGHT: reg_height = data;
            mpnf_pkg::CFG_MASK:   reg_mask   = data[8:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h, input logic [8:0] m);
        write_reg(mpnf_pkg::CFG_WIDTH, w);
        write_reg(mpnf_pkg::CFG_HEIGHT, h);
        write_reg(mpnf_pkg::CFG_MASK, {2'b00, m});
    endtask

    // Masked pixels at mask_pct percent, rest from a small cluster or anywhere.
    function automatic logic [7:0] pick_index(input int mask_pct);
        if (!reg_mask[8] && $urandom_range(0, 99) < mask_pct) return reg_mask[7:0];
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // Whole frame plus its drain; noise items scattered when asked.
    task automatic run_frame(input int mask_pct, input bit noisy);
        int unsigned w, h;
        w = width_now();
        h = height_now();
        for (int unsigned n = 0; n < w * h; n++) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_item(mpnf_pkg::OP_NONE, 8'($urandom), 8'($urandom), $urandom);
                    1: send_drain();  // not pending: no effect
                    default: send_item(mpnf_pkg::OP_LOAD, 8'($urandom), 8'($urandom),
                                       $urandom);
                endcase
            end
            send_pixel(pick_index(mask_pct));
        end
        if (noisy && $urandom_range(0, 2) == 0) send_pixel(8'($urandom));  // dropped
        for (int unsigned n = 0; n < w; n++) send_drain();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_palette_fill();
        for (int a = 0; a < mpnf_pkg::PALETTE_ENTRIES; a++) begin
            case (a)
                0:       send_item(mpnf_pkg::OP_LOAD, 8'($urandom), 8'(a), 32'h0000_0000);
                255:     send_item(mpnf_pkg::OP_LOAD, 8'($urandom), 8'(a), 32'hFFFF_FFFF);
                default: send_item(mpnf_pkg::OP_LOAD, 8'($urandom), 8'(a), $urandom);
            endcase
        end
    endtask

    task automatic test_single_pixel();
        // width 0 and height 0 behave as 1x1
        set_frame(11'd0, 11'd0, 9'h1FF);
        send_drain();                          // nothing pending
        send_item(mpnf_pkg::OP_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_pixel(8'd255);
        send_pixel(8'd0);                      // drain pending: dropped
        send_drain();
        // lone masked pixel has no neighbor: black, alpha 0
        write_reg(mpnf_pkg::CFG_MASK, 11'd5);
        send_pixel(8'd5);
        send_drain();
    endtask

    task automatic test_masked_blocks();
        set_frame(11'd4, 11'd3, 9'd7);
        for (int n = 0; n < 12; n++) send_pixel((n % 4 == 3) ? 8'd1 : 8'd7);
        for (int n = 0; n < 4; n++) send_drain();
        // negative mask other than -1: nothing is masked
        set_frame(11'd3, 11'd2, 9'h100);
        run_frame(0, 1'b0);
        write_reg(mpnf_pkg::CFG_MASK, 11'd0);
        run_frame(60, 1'b0);
    endtask

    // Width drops while rows are in flight, then again during the drain.
    task automatic test_width_shrink();
        set_frame(11'd8, 11'd4, 9'd2);
        for (int n = 0; n < 21; n++) send_pixel(pick_index(40));
        write_reg(mpnf_pkg::CFG_WIDTH, 11'd3);
        for (int n = 0; n < 4; n++) send_pixel(pick_index(40));
        send_drain();
        send_drain();
        write_reg(mpnf_pkg::CFG_WIDTH, 11'd1);
        send_drain();
    endtask

    // Receiver holds off while the sender keeps offering; then full pause.
    task automatic test_backpressure();
        set_frame(11'd16, 11'd6, 9'd3);
        tx_gaps = 1'b0;
        holds_asked++;
        run_frame(30, 1'b0);
        tx_gaps = 1'b1;
        wait_idle();
    endtask

    // Wider rows than the random frames use.
    task automatic test_full_width();
        set_frame(11'd40, 11'd2, 9'd1);
        run_frame(25, 1'b0);
        set_frame(11'd64, 11'd1, 9'd0);
        run_frame(10, 1'b0);
    endtask

    task automatic random_frame();
        logic [8:0] m;
        case ($urandom_range(0, 5))
            0:       m = 9'h1FF;
            1:       m = {1'b1, 8'($urandom)};
            2:       m = 9'($urandom_range(0, 255));
            default: m = 9'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 9) == 0) set_frame(11'd0, 11'($urandom_range(0, 3)), m);
        else set_frame(11'($urandom_range(1, 16)), 11'($urandom_range(1, 5)), m);
        tx_gaps   = $urandom_range(0, 3) != 0;
        rx_bursts = $urandom_range(0, 3) != 0;
        run_frame($urandom_range(0, 70), 1'b1);
    endtask

    task automatic test_random();
        int unsigned start;
        start = sent_items;
        while (sent_items - start < RAND_ITEMS) random_frame();
        // last stretch with no idling anywhere
        quiet = 1'b1;
        start = sent_items;
        while (sent_items - start < QUIET_ITEMS) random_frame();
    endtask

    // ------------------------------------------------------------------
    // Output side: stall bursts, long hold on request, result checking
    // ------------------------------------------------------------------
    int unsigned hold_left  = 0;
    int unsigned holds_seen = 0;
    int unsigned burst_left = 0;
    bit          burst_on   = 1'b0;

    always @(posedge i_clk) begin
        if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            hold_left  = HOLD_CYC;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (quiet || !rx_bursts) begin
            i_out_stall <= 1'b0;
        end else begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 19);
                burst_on   = $urandom_range(0, 2) == 0;
            end
            burst_left--;
            i_out_stall <= burst_on;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h (result queue %0d)",
                 what, got, want, pixels_due.size());
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_rgba e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixels_due.size() == 0) begin
                report("unexpected transfer", {o_alpha, o_blue, o_green, o_red}, '0);
            end else begin
                e = pixels_due.pop_front();
                if (o_red !== e.red)
                    report("red", 32'(o_red), 32'(e.red));
                if (o_green !== e.green)
                    report("green", 32'(o_green), 32'(e.green));
                if (o_blue !== e.blue)
                    report("blue", 32'(o_blue), 32'(e.blue));
                if (o_alpha !== e.alpha)
                    report("alpha", 32'(o_alpha), 32'(e.alpha));
                if (o_end_of_run !== e.eor)
                    report("end_of_run", 32'(o_end_of_run), 32'(e.eor));
                if (o_end_of_frame !== e.eof)
                    report("end_of_frame", 32'(o_end_of_frame), 32'(e.eof));
            end
        end
    end

    // Watchdog: cycles without any transfer on any channel.
    int unsigned dead_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            dead_cycles = 0;
        end else if (++dead_cycles >= IDLE_LIMIT) begin
            $display("FAIL masked_pixel_neighbor_color_fill_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        col_pos = 0; row_pos = 0; drain_pos = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_palette_fill();
        test_single_pixel();
        test_masked_blocks();
        test_width_shrink();
        test_backpressure();
        test_full_width();
        test_random();
        wait_idle();
        if (errors == 0 && pixels_due.size() == 0) begin
            $display("PASS masked_pixel_neighbor_color_fill_top");
        end else begin
            $display("FAIL masked_pixel_neighbor_color_fill_top");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/mpnf_pkg.sv
hdl/mpnf_avg.sv
hdl/masked_pixel_neighbor_color_fill_top.sv
hdl/mpnf_checker.sv
verif/tb_masked_pixel_neighbor_color_fill_top.sv
